/* rtl/core/dwr_pkg.sv */
package dwr_pkg;

  // Field widths fixed by the request and result formats
  localparam int unsigned KIND_W  = 1;
  localparam int unsigned SIZE_W  = 5;
  localparam int unsigned WORD_W  = 31;
  localparam int unsigned VALUE_W = 4;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_DRAW   = 1'b0;
  localparam logic [KIND_W-1:0] KIND_REFILL = 1'b1;

  // Result status codes
  localparam logic STATUS_DRAWN = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  // Bit counter of the serial remainder unit
  localparam int unsigned DIV_CNT_W = $clog2(WORD_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(WORD_W - 1);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SIZE_W-1:0] pool_size;
    logic [WORD_W-1:0] random_word;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] drawn_value;
    logic               status;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;     // take a new request
    logic fill_wr;     // write the next refill entry
    logic div_step;    // one restoring remainder step
    logic mem_rd;      // read the chosen slot and the last live entry
    logic draw_wr;     // move last entry into slot, emit value, decrement
    logic emit_empty;  // emit an empty-pool result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic fill_done;
    logic count_zero;
    logic div_done;
  } sts_t;

endpackage

/* rtl/core/draw_without_replacement.sv */
// Draw without replacement: hands out 0..n-1 in random order, each once.
// Request channel: req_i is taken at a rising edge where start is high and
// busy is low. A refill request loads the pool with 0..pool_size-1 (capped
// at POOL_DEPTH) and then draws; a draw request draws from the current pool.
// Result channel: rsp_o is valid for exactly one cycle, flagged by
// result_valid_o; there is no back-pressure, the receiver must take it.
// From accept to result a draw passes through the refill, if any, then the
// remainder unit, the pool read and the pool write; an empty pool answers
// once the refill is done. The cost is set by the one-bit-per-cycle remainder
// unit (31 steps for the random word) and by the single write port of the
// pool memory, which takes one refill entry per cycle.
// The next request is taken in the cycle its predecessor's result shows.
// Reset clears the live count, so the pool reads as empty until the first
// refill; the pool memory itself is not cleared.
module draw_without_replacement #(
  parameter int unsigned POOL_DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  dwr_pkg::req_t req_i,
  output logic          result_valid_o,
  output dwr_pkg::rsp_t rsp_o
);

  dwr_pkg::cmd_t cmd;
  dwr_pkg::sts_t sts;

  dwr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  dwr_dpath #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o)
  );

  // A result only appears once the controller is back in idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

  // An accepted request always occupies the block in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // One result per request: strobes never come back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("back-to-back result strobes");

  // An empty-pool result carries a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (rsp_o.status == dwr_pkg::STATUS_EMPTY)) |-> (rsp_o.drawn_value == '0))
    else $error("empty result with non-zero value");

endmodule

/* rtl/core/dwr_ctrl.sv */
module dwr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  dwr_pkg::sts_t sts_i,
  output dwr_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FILL = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;

  logic [2:0] state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = S_FILL;
        end
      end
      S_FILL: begin
        if (!sts_i.fill_done) begin
          cmd_o.fill_wr = 1'b1;
        end else if (sts_i.count_zero) begin
          cmd_o.emit_empty = 1'b1;
          state_d          = S_IDLE;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_WR;
      end
      S_WR: begin
        cmd_o.draw_wr = 1'b1;
        state_d       = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/dwr_dpath.sv */
module dwr_dpath #(
  parameter int unsigned POOL_DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dwr_pkg::req_t req_i,
  input  dwr_pkg::cmd_t cmd_i,
  output dwr_pkg::sts_t sts_o,
  output logic          result_valid_o,
  output dwr_pkg::rsp_t rsp_o
);

  localparam int unsigned AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned CW = $clog2(POOL_DEPTH + 1);
  localparam int unsigned RW = CW + 1;

  // Pool memory, reset value undefined
  logic [AW-1:0] pool_mem [POOL_DEPTH];

  logic                              refill_q;
  logic [dwr_pkg::WORD_W-1:0]        word_q;
  logic [CW-1:0]                     count_q, count_d;
  logic [CW-1:0]                     fill_idx_q;
  logic [CW-1:0]                     rem_q;
  logic [dwr_pkg::DIV_CNT_W-1:0]     div_cnt_q;
  logic [AW-1:0]                     slot_data_q, last_data_q;
  logic                              valid_q;
  dwr_pkg::rsp_t                     rsp_q;

  logic [CW-1:0]     size_sat;
  logic [RW-1:0]     rem_shift, rem_sub;
  logic              rem_ge;
  logic [CW-1:0]     last_idx;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_wdata;
  logic [AW+3:0]     value_ext;

  // Refill size saturated to the pool depth
  assign size_sat = (32'(req_i.pool_size) > 32'(POOL_DEPTH)) ? CW'(POOL_DEPTH)
                                                             : CW'(req_i.pool_size);

  // One restoring remainder step, MSB of the word first
  assign rem_shift = {rem_q, word_q[dwr_pkg::WORD_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, count_q});
  assign rem_sub   = rem_shift - {1'b0, count_q};

  assign last_idx = count_q - CW'(1);

  // Status to the controller
  assign sts_o.fill_done  = (refill_q != dwr_pkg::KIND_REFILL) || (fill_idx_q == count_q);
  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.div_done   = (div_cnt_q == dwr_pkg::DIV_LAST);

  // Live count: loaded on a refill request, decremented on a draw
  always_comb begin
    count_d = count_q;
    if (cmd_i.capture && (req_i.kind == dwr_pkg::KIND_REFILL)) begin
      count_d = size_sat;
    end else if (cmd_i.draw_wr) begin
      count_d = last_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= cmd_i.draw_wr || cmd_i.emit_empty;
    end
  end

  // Request capture, refill index and remainder unit
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      refill_q   <= req_i.kind;
      word_q     <= req_i.random_word;
      fill_idx_q <= '0;
      rem_q      <= '0;
      div_cnt_q  <= '0;
    end else begin
      if (cmd_i.fill_wr) begin
        fill_idx_q <= fill_idx_q + CW'(1);
      end
      if (cmd_i.div_step) begin
        rem_q     <= rem_ge ? rem_sub[CW-1:0] : rem_shift[CW-1:0];
        word_q    <= {word_q[dwr_pkg::WORD_W-2:0], 1'b0};
        div_cnt_q <= div_cnt_q + dwr_pkg::DIV_CNT_W'(1);
      end
    end
  end

  // Single write port shared by refill and draw
  assign mem_we    = cmd_i.fill_wr || cmd_i.draw_wr;
  assign mem_waddr = cmd_i.fill_wr ? fill_idx_q[AW-1:0] : rem_q[AW-1:0];
  assign mem_wdata = cmd_i.fill_wr ? fill_idx_q[AW-1:0] : last_data_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pool_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.mem_rd) begin
      slot_data_q <= pool_mem[rem_q[AW-1:0]];
      last_data_q <= pool_mem[last_idx[AW-1:0]];
    end
  end

  // Result register
  assign value_ext = {4'b0000, slot_data_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.draw_wr) begin
      rsp_q.drawn_value <= value_ext[3:0];
      rsp_q.status      <= dwr_pkg::STATUS_DRAWN;
    end else if (cmd_i.emit_empty) begin
      rsp_q.drawn_value <= '0;
      rsp_q.status      <= dwr_pkg::STATUS_EMPTY;
    end
  end

  assign result_valid_o = valid_q;
  assign rsp_o          = rsp_q;

endmodule
